FILE: sv/tpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types and constants for the touch press holdoff mapper.
// ----------------------------------------------------------------------------
package tpm_pkg;

  // Configuration port
  localparam int unsigned AddrW   = 5;   // eight 32-bit registers
  localparam int unsigned DataW   = 32;
  localparam int unsigned RotW    = 8;
  localparam int unsigned HoldW   = 16;

  typedef enum logic [2:0] {
    REG_ROTATION   = 3'd0,
    REG_HOLDOFF    = 3'd1,
    REG_CAL_B_LOW  = 3'd2,
    REG_CAL_B_HIGH = 3'd3,
    REG_CAL_A_STRT = 3'd4,
    REG_CAL_A_END  = 3'd5,
    REG_SCR_WIDTH  = 3'd6,
    REG_SCR_HEIGHT = 3'd7
  } reg_idx_e;

  // Register reset values
  localparam int unsigned RstRotation  = 1;
  localparam int unsigned RstHoldoff   = 100;
  localparam int unsigned RstCalBLow   = 190;
  localparam int unsigned RstCalBHigh  = 3760;
  localparam int unsigned RstCalAStart = 3820;
  localparam int unsigned RstCalAEnd   = 260;
  localparam int unsigned RstScrWidth  = 480;
  localparam int unsigned RstScrHeight = 320;

  // Rotation value that selects the pixel mapping
  localparam logic [RotW-1:0] RotMapped = 8'd1;

  // Result kinds
  localparam int unsigned ActW = 2;
  typedef enum logic [ActW-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_DISCARD = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  // Input flag positions in tuser
  localparam int unsigned FlagReady = 0;
  localparam int unsigned FlagPen   = 1;

  // Sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_X,
    ST_WAIT_X,
    ST_MAP_Y,
    ST_WAIT_Y,
    ST_EMIT
  } state_e;

endpackage

FILE: sv/tpm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_regs
// APB register file holding mode, holdoff, calibration and screen size settings.
// ----------------------------------------------------------------------------
module tpm_regs
  import tpm_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [DataW-1:0]      pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready,
  output logic [RotW-1:0]       rotation_o,
  output logic [HoldW-1:0]      holdoff_o,
  output logic [COORD_BITS-1:0] cal_b_low_o,
  output logic [COORD_BITS-1:0] cal_b_high_o,
  output logic [COORD_BITS-1:0] cal_a_start_o,
  output logic [COORD_BITS-1:0] cal_a_end_o,
  output logic [COORD_BITS-1:0] scr_width_o,
  output logic [COORD_BITS-1:0] scr_height_o
);

  logic [RotW-1:0]       rot_q;
  logic [HoldW-1:0]      hold_q;
  logic [COORD_BITS-1:0] b_low_q, b_high_q, a_start_q, a_end_q, width_q, height_q;
  logic                  wr_en;
  reg_idx_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q     <= RotW'(RstRotation);
      hold_q    <= HoldW'(RstHoldoff);
      b_low_q   <= COORD_BITS'(RstCalBLow);
      b_high_q  <= COORD_BITS'(RstCalBHigh);
      a_start_q <= COORD_BITS'(RstCalAStart);
      a_end_q   <= COORD_BITS'(RstCalAEnd);
      width_q   <= COORD_BITS'(RstScrWidth);
      height_q  <= COORD_BITS'(RstScrHeight);
    end else if (wr_en) begin
      case (idx)
        REG_ROTATION:   rot_q     <= pwdata[RotW-1:0];
        REG_HOLDOFF:    hold_q    <= pwdata[HoldW-1:0];
        REG_CAL_B_LOW:  b_low_q   <= pwdata[COORD_BITS-1:0];
        REG_CAL_B_HIGH: b_high_q  <= pwdata[COORD_BITS-1:0];
        REG_CAL_A_STRT: a_start_q <= pwdata[COORD_BITS-1:0];
        REG_CAL_A_END:  a_end_q   <= pwdata[COORD_BITS-1:0];
        REG_SCR_WIDTH:  width_q   <= pwdata[COORD_BITS-1:0];
        REG_SCR_HEIGHT: height_q  <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROTATION:   prdata = DataW'(rot_q);
      REG_HOLDOFF:    prdata = DataW'(hold_q);
      REG_CAL_B_LOW:  prdata = DataW'(b_low_q);
      REG_CAL_B_HIGH: prdata = DataW'(b_high_q);
      REG_CAL_A_STRT: prdata = DataW'(a_start_q);
      REG_CAL_A_END:  prdata = DataW'(a_end_q);
      REG_SCR_WIDTH:  prdata = DataW'(width_q);
      REG_SCR_HEIGHT: prdata = DataW'(height_q);
      default:        prdata = '0;
    endcase
  end

  assign rotation_o    = rot_q;
  assign holdoff_o     = hold_q;
  assign cal_b_low_o   = b_low_q;
  assign cal_b_high_o  = b_high_q;
  assign cal_a_start_o = a_start_q;
  assign cal_a_end_o   = a_end_q;
  assign scr_width_o   = width_q;
  assign scr_height_o  = height_q;

endmodule

FILE: sv/tpm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpm_divider #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [2*COORD_BITS-1:0] dividend_i,
  input  logic [COORD_BITS-1:0]   divisor_i,
  output logic                    done_o,
  output logic [2*COORD_BITS-1:0] quotient_o
);

  localparam int unsigned DW   = 2 * COORD_BITS;
  localparam int unsigned CntW = $clog2(DW);

  logic [DW-1:0]         dvd_q, dvd_d;     // dividend shifts out, quotient shifts in
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] dvs_q;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [COORD_BITS:0]   rem_sh, rem_sub;
  logic                  fits;

  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
      dvd_d = {dvd_q[DW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

FILE: sv/tpm_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_axis
// Shared coordinate map unit: sign/magnitude multiply, iterative divide,
// clamp to the screen span.
// ----------------------------------------------------------------------------
module tpm_axis #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] raw_i,
  input  logic [COORD_BITS-1:0] lo_i,
  input  logic [COORD_BITS-1:0] hi_i,
  input  logic [COORD_BITS-1:0] span_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] result_o
);

  localparam int unsigned DW = 2 * COORD_BITS;

  logic [COORD_BITS:0]   diff, den;
  logic [COORD_BITS:0]   diff_neg, den_neg;
  logic [COORD_BITS-1:0] diff_mag, den_mag;
  logic [DW-1:0]         prod;

  logic [DW-1:0]         num_q;
  logic [COORD_BITS-1:0] den_q, span_q;
  logic                  zero_q;
  logic                  div_start_q;

  logic [DW-1:0]         quot;

  // Truncating signed divide: a negative quotient clamps to zero anyway,
  // so only same-sign operands need the magnitude divide.
  assign diff     = {1'b0, raw_i} - {1'b0, lo_i};
  assign den      = {1'b0, hi_i} - {1'b0, lo_i};
  assign diff_neg = -diff;
  assign den_neg  = -den;
  assign diff_mag = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];
  assign den_mag  = den[COORD_BITS] ? den_neg[COORD_BITS-1:0] : den[COORD_BITS-1:0];
  assign prod     = DW'(diff_mag) * DW'(span_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= prod;
      den_q  <= den_mag;
      span_q <= span_i;
      zero_q <= (den == '0) | (diff[COORD_BITS] ^ den[COORD_BITS]);
    end
  end

  tpm_divider #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (num_q),
    .divisor_i  (den_q),
    .done_o     (done_o),
    .quotient_o (quot)
  );

  always_comb begin
    if (zero_q) begin
      result_o = '0;
    end else if (quot > DW'(span_q)) begin
      result_o = span_q;
    end else begin
      result_o = quot[COORD_BITS-1:0];
    end
  end

endmodule

FILE: sv/touch_press_holdoff_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_holdoff_mapper
// Touch poll filter: press holdoff after release, pixel mapping, release.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side request is one controller poll. The block keeps a touched
//   flag and the last release time and returns zero or one master-side
//   request per poll: press (with coordinates), press discarded during
//   holdoff, or release. Polls that change nothing give no result. The
//   user must write settings over APB while the block is idle (not enforced).
// Flow:
//   Discards, releases and unmapped presses go straight from the accept
//   to the emit step, which loads the output register; the next poll is
//   taken once the sequencer is back in idle. Polls that give no result
//   leave tready high. A mapped press runs both axes through one shared
//   multiply/divide unit one after the other; each axis registers the
//   product, loads the divider, runs the divider (one quotient bit per
//   cycle) and raises done. No new poll is taken while an item is in the
//   sequencer.
// Reset: registers take their defaults, not touched, release time zero.
// Stall: the result sits in an output register; a new poll is still taken
//   while it waits, and the next result waits in its emit step until the
//   output register frees up.
// ----------------------------------------------------------------------------
module touch_press_holdoff_mapper
  import tpm_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave tdata: raw_a, raw_b, now_ms (low bit up), zero padded to bytes
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((2*COORD_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // slave tuser: sample_ready, pen_down (low bit up)
  input  logic [1:0]            s_axis_tuser,
  // master tdata: pos_x, pos_y (low bit up), zero padded to bytes
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // master tuser: action
  output logic [ActW-1:0]       m_axis_tuser,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [DataW-1:0]      pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  localparam int unsigned COutW = ((2*COORD_BITS+7)/8)*8;
  localparam int unsigned APos  = 0;
  localparam int unsigned BPos  = COORD_BITS;
  localparam int unsigned TPos  = 2 * COORD_BITS;

  // settings
  logic [RotW-1:0]       rotation;
  logic [HoldW-1:0]      holdoff;
  logic [COORD_BITS-1:0] cal_b_low, cal_b_high, cal_a_start, cal_a_end;
  logic [COORD_BITS-1:0] scr_width, scr_height;

  tpm_regs #(
    .COORD_BITS(COORD_BITS)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .rotation_o    (rotation),
    .holdoff_o     (holdoff),
    .cal_b_low_o   (cal_b_low),
    .cal_b_high_o  (cal_b_high),
    .cal_a_start_o (cal_a_start),
    .cal_a_end_o   (cal_a_end),
    .scr_width_o   (scr_width),
    .scr_height_o  (scr_height)
  );

  // poll fields
  logic                  in_ready, in_pen;
  logic [COORD_BITS-1:0] in_a, in_b;
  logic [TIME_BITS-1:0]  in_now, elapsed;

  assign in_ready = s_axis_tuser[FlagReady];
  assign in_pen   = s_axis_tuser[FlagPen];
  assign in_a     = s_axis_tdata[APos +: COORD_BITS];
  assign in_b     = s_axis_tdata[BPos +: COORD_BITS];
  assign in_now   = s_axis_tdata[TPos +: TIME_BITS];

  // sequencer state
  state_e                state_q, state_d;
  logic                  touched_q, touched_d;
  logic [TIME_BITS-1:0]  rel_time_q, rel_time_d;
  logic [COORD_BITS-1:0] ra_q, ra_d, rb_q, rb_d;
  action_e               act_q, act_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  action_e               out_act_q;
  logic [COORD_BITS-1:0] out_x_q, out_y_q;
  logic                  out_load;

  // shared map unit
  logic                  ax_start, ax_sel_y, ax_done;
  logic [COORD_BITS-1:0] ax_raw, ax_lo, ax_hi, ax_span, ax_result;

  assign elapsed  = in_now - rel_time_q;
  assign ax_sel_y = (state_q == ST_MAP_Y);
  assign ax_raw   = ax_sel_y ? ra_q        : rb_q;
  assign ax_lo    = ax_sel_y ? cal_a_start : cal_b_low;
  assign ax_hi    = ax_sel_y ? cal_a_end   : cal_b_high;
  assign ax_span  = ax_sel_y ? scr_height  : scr_width;

  tpm_axis #(
    .COORD_BITS(COORD_BITS)
  ) u_axis (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ax_start),
    .raw_i    (ax_raw),
    .lo_i     (ax_lo),
    .hi_i     (ax_hi),
    .span_i   (ax_span),
    .done_o   (ax_done),
    .result_o (ax_result)
  );

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    touched_d  = touched_q;
    rel_time_d = rel_time_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    act_d      = act_q;
    px_d       = px_q;
    py_d       = py_q;
    ax_start   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (!touched_q && in_ready) begin
            px_d = '0;
            py_d = '0;
            if (elapsed < TIME_BITS'(holdoff)) begin
              // too soon after release: report and drop
              act_d   = ACT_DISCARD;
              state_d = ST_EMIT;
            end else begin
              act_d     = ACT_PRESS;
              touched_d = 1'b1;
              if (rotation == RotMapped) begin
                ra_d    = in_a;
                rb_d    = in_b;
                state_d = ST_MAP_X;
              end else begin
                px_d    = in_a;
                py_d    = in_b;
                state_d = ST_EMIT;
              end
            end
          end else if (touched_q && !in_pen) begin
            act_d      = ACT_RELEASE;
            px_d       = '0;
            py_d       = '0;
            touched_d  = 1'b0;
            rel_time_d = in_now;
            state_d    = ST_EMIT;
          end
        end
      end
      ST_MAP_X: begin
        ax_start = 1'b1;
        state_d  = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (ax_done) begin
          px_d    = ax_result;
          state_d = ST_MAP_Y;
        end
      end
      ST_MAP_Y: begin
        ax_start = 1'b1;
        state_d  = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (ax_done) begin
          py_d    = ax_result;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      touched_q   <= 1'b0;
      rel_time_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      touched_q   <= touched_d;
      rel_time_q  <= rel_time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q  <= ra_d;
    rb_q  <= rb_d;
    act_q <= act_d;
    px_q  <= px_d;
    py_q  <= py_d;
    if (out_load) begin
      out_act_q <= act_q;
      out_x_q   <= px_q;
      out_y_q   <= py_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_act_q;
  assign m_axis_tdata  = COutW'({out_y_q, out_x_q});

endmodule
